@@ hw/rtl/rgbamip_pkg.sv @@
// Shared types and constants for the RGBA 2x2 box-filter mipmap downsampler.
package rgbamip_pkg;

  localparam int CHAN_W     = 8;
  localparam int SUM_W      = 10;
  localparam int ACC_W      = SUM_W + 1;
  localparam int LINE_W     = 4 * SUM_W;
  localparam int REG_W      = 11;
  localparam int ROW_W      = 10;
  localparam int POS_W      = 13;
  localparam int MAX_HEIGHT = 1024;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } texel_t;

  typedef struct packed {
    logic [SUM_W-1:0] alpha;
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } line_t;

  typedef struct packed {
    logic [REG_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic [ROW_W-1:0] done_row;
    logic             restart;
  } cfg_t;

endpackage

@@ hw/rtl/rgbamip_stream_if.sv @@
// Valid/ready stream interfaces for input texels and downsampled texels.
interface rgbamip_texel_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output in_alpha, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                input in_alpha, output ready);
endinterface

interface rgbamip_mip_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       level_done;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_alpha, output level_done, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_alpha, input level_done, output ready);
endinterface

@@ hw/rtl/rgbamip_cfg_regs.sv @@
// APB register block holding image width and height and their derived limits.
module rgbamip_cfg_regs #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rgbamip_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rgbamip_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rgbamip_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                pready,
  output rgbamip_pkg::cfg_t                   cfg
);
  import rgbamip_pkg::*;

  localparam int MAXW_EVEN = MAX_WIDTH - (MAX_WIDTH % 2);

  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;
  logic             write_en;
  cfg_reg_t         reg_sel;
  logic [POS_W-1:0] width_even;
  logic [POS_W-1:0] eff_width;
  logic [REG_W-1:0] eff_height;
  logic [REG_W-1:0] height_even;

  assign pready   = 1'b1;
  assign write_en = psel && penable && pwrite && pready;
  assign reg_sel  = cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= REG_W'(2);
      image_height <= REG_W'(2);
    end else if (write_en) begin
      case (reg_sel)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    width_even = POS_W'(image_width & REG_W'(11'h7FE));
    if (width_even < POS_W'(2)) begin
      eff_width = POS_W'(2);
    end else if (width_even > POS_W'(MAXW_EVEN)) begin
      eff_width = POS_W'(MAXW_EVEN);
    end else begin
      eff_width = width_even;
    end
    if (image_height == '0) begin
      eff_height = REG_W'(1);
    end else if (image_height > REG_W'(MAX_HEIGHT)) begin
      eff_height = REG_W'(MAX_HEIGHT);
    end else begin
      eff_height = image_height;
    end
    height_even = eff_height & REG_W'(11'h7FE);
  end

  assign cfg.last_col = REG_W'(eff_width - POS_W'(1));
  assign cfg.last_row = ROW_W'(eff_height - REG_W'(1));
  assign cfg.done_row = ROW_W'(height_even - REG_W'(1));
  assign cfg.restart  = write_en;

endmodule

@@ hw/rtl/rgbamip_line_mem.sv @@
// Line store of horizontal pair sums, one write and one registered read port.
module rgbamip_line_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [rgbamip_pkg::LINE_W-1:0] wdata,
  input  logic                           re,
  input  logic [AW-1:0]                  raddr,
  output logic [rgbamip_pkg::LINE_W-1:0] rdata
);
  import rgbamip_pkg::*;

  logic [LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/rgba_box_mipmap_downsample_unit.sv @@
// Top level of the RGBA 2x2 box-filter mipmap downsampler.
//
// Texels of one image enter on the texel channel in row-major order and the
// next mip level leaves on the mip channel, one texel per 2x2 block, each
// channel the truncated average of the four. image_width (byte address 0)
// and image_height (address 4) are set over the APB port while the block is
// idle; any write also restarts the image at column and row zero.
// One texel is accepted per cycle, unless stalled, whatever the image shape.
// The first texel of a pair in an odd row reads the line store, the second
// one adds the pair sums of the row above; the averaged texel is valid in the
// cycle after the second texel is accepted. Even rows only write the line
// store and produce no output; an odd last row is consumed without output.
// level_done marks the last output texel of the image.
// The single output register holds a result while the receiver stalls; the
// input keeps taking texels whenever that register is empty or being taken.
// Reset clears positions, the output valid flag and the registers to a 2x2
// image; the line store needs no clearing as every read follows a write.
module rgba_box_mipmap_downsample_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  rgbamip_texel_if.sink                      texel,
  rgbamip_mip_if.source                      mip,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rgbamip_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rgbamip_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rgbamip_pkg::APB_DATA_W-1:0] prdata,
  output logic                               pready
);
  import rgbamip_pkg::*;

  localparam int MAXW_EVEN = MAX_WIDTH - (MAX_WIDTH % 2);
  localparam int CW        = (MAXW_EVEN > 2) ? $clog2(MAXW_EVEN) : 1;
  localparam int DEPTH     = MAXW_EVEN / 2;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t              cfg;
  logic [CW-1:0]     col;
  logic [ROW_W-1:0]  row;
  texel_t            first;
  texel_t            in_texel;
  line_t             pair_sum;
  line_t             above;
  logic [LINE_W-1:0] mem_rdata;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic              accept;
  logic              col_last;
  logic              row_last;
  logic              result;
  logic [ACC_W-1:0]  acc_red;
  logic [ACC_W-1:0]  acc_green;
  logic [ACC_W-1:0]  acc_blue;
  logic [ACC_W-1:0]  acc_alpha;
  logic              out_valid;
  texel_t            out_texel;
  logic              out_done;

  rgbamip_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rgbamip_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (LINE_W'(pair_sum)),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  assign in_texel.red   = texel.in_red;
  assign in_texel.green = texel.in_green;
  assign in_texel.blue  = texel.in_blue;
  assign in_texel.alpha = texel.in_alpha;

  assign texel.ready = !out_valid || mip.ready;
  assign accept      = texel.valid && texel.ready;
  assign col_last    = (POS_W'(col) == POS_W'(cfg.last_col));
  assign row_last    = (row == cfg.last_row);
  assign mem_addr    = AW'(col >> 1);
  assign mem_we      = accept && col[0] && !row[0];
  assign mem_re      = accept && !col[0] && row[0];
  assign result      = accept && col[0] && row[0];

  assign pair_sum.red   = SUM_W'(first.red) + SUM_W'(in_texel.red);
  assign pair_sum.green = SUM_W'(first.green) + SUM_W'(in_texel.green);
  assign pair_sum.blue  = SUM_W'(first.blue) + SUM_W'(in_texel.blue);
  assign pair_sum.alpha = SUM_W'(first.alpha) + SUM_W'(in_texel.alpha);

  assign above     = line_t'(mem_rdata);
  assign acc_red   = ACC_W'(above.red) + ACC_W'(pair_sum.red);
  assign acc_green = ACC_W'(above.green) + ACC_W'(pair_sum.green);
  assign acc_blue  = ACC_W'(above.blue) + ACC_W'(pair_sum.blue);
  assign acc_alpha = ACC_W'(above.alpha) + ACC_W'(pair_sum.alpha);

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !col[0]) begin
      first <= in_texel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result) begin
      out_valid <= 1'b1;
    end else if (mip.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result) begin
      out_texel.red   <= CHAN_W'(acc_red >> 2);
      out_texel.green <= CHAN_W'(acc_green >> 2);
      out_texel.blue  <= CHAN_W'(acc_blue >> 2);
      out_texel.alpha <= CHAN_W'(acc_alpha >> 2);
      out_done        <= (row == cfg.done_row) && col_last;
    end
  end

  assign mip.valid      = out_valid;
  assign mip.out_red    = out_texel.red;
  assign mip.out_green  = out_texel.green;
  assign mip.out_blue   = out_texel.blue;
  assign mip.out_alpha  = out_texel.alpha;
  assign mip.level_done = out_done;

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("line store read and written in one cycle");

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    POS_W'(col) <= POS_W'(cfg.last_col))
    else $error("column position beyond row width");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    result |=> out_valid)
    else $error("completed block not presented");

  a_done_wraps_col: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_done) |-> (col == '0))
    else $error("level done without column wrap");

endmodule
